FILE: rtl/core/twpm_pkg.sv
package twpm_pkg;

  localparam int ADDR_W = 5;

  localparam int SECS_PER_DAY  = 24 * 60 * 60;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int DAYS_PER_WEEK = 7;
  localparam int EPOCH_WDAY    = 3;

  localparam int REM_W = 33;
  localparam int QUO_W = 16;
  localparam int CNT_W = 4;

  // quotient step, then remainder step
  localparam int DIV_STEPS = 2;

  // floor(x / d) = (x * ceil(2^k / d)) >> k over the operand range used
  // day: x = t >> 7, d = 675; hour: x = sod >> 4, d = 225; minute: x = r >> 2, d = 15
  localparam logic [26:0] DAY_RECIP   = 27'd101806633;
  localparam logic [13:0] HOUR_RECIP  = 14'd9321;
  localparam logic [10:0] MIN_RECIP   = 11'd1093;
  localparam logic [16:0] WDAY_RECIP  = 17'd74899;
  localparam int          DAY_RSHIFT  = 36;
  localparam int          HOUR_RSHIFT = 21;
  localparam int          MIN_RSHIFT  = 14;
  localparam int          WDAY_RSHIFT = 19;

  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;

  localparam logic [6:0]  DEF_DAY_MASK = 7'd0;
  localparam logic [10:0] DEF_START    = 11'd0;
  localparam logic [10:0] DEF_STOP     = 11'd1439;

  typedef enum logic [2:0] {
    REG_DAY_MASK  = 3'd0,
    REG_START_MIN = 3'd1,
    REG_STOP_MIN  = 3'd2,
    REG_TZ_WEST   = 3'd3,
    REG_EXTRA_OFS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [6:0]         day_mask;
    logic [10:0]        start_minute;
    logic [10:0]        stop_minute;
    logic signed [10:0] tz_minutes_west;
    logic signed [17:0] extra_offset_seconds;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY,
    S_HOUR_INIT,
    S_HOUR,
    S_MIN_INIT,
    S_MIN,
    S_WDAY_INIT,
    S_WDAY,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_HOUR_INIT,
    OP_MIN_INIT,
    OP_WDAY_INIT,
    OP_YEAR,
    OP_MONTH,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WDAY
  } div_sel_t;

  typedef struct packed {
    logic div_last;
    logic year_done;
  } dp_stat_t;

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/twpm_regs.sv
module twpm_regs
  import twpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.day_mask             <= DEF_DAY_MASK;
      cfg.start_minute         <= DEF_START;
      cfg.stop_minute          <= DEF_STOP;
      cfg.tz_minutes_west      <= '0;
      cfg.extra_offset_seconds <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_DAY_MASK:  cfg.day_mask             <= pwdata[6:0];
        REG_START_MIN: cfg.start_minute         <= pwdata[10:0];
        REG_STOP_MIN:  cfg.stop_minute          <= pwdata[10:0];
        REG_TZ_WEST:   cfg.tz_minutes_west      <= pwdata[10:0];
        REG_EXTRA_OFS: cfg.extra_offset_seconds <= pwdata[17:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DAY_MASK:  prdata = {25'd0, cfg.day_mask};
      REG_START_MIN: prdata = {21'd0, cfg.start_minute};
      REG_STOP_MIN:  prdata = {21'd0, cfg.stop_minute};
      REG_TZ_WEST:   prdata = 32'(cfg.tz_minutes_west);
      REG_EXTRA_OFS: prdata = 32'(cfg.extra_offset_seconds);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/twpm_ctrl.sv
module twpm_ctrl
  import twpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output op_t      op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      S_IDLE:      state_next = start ? S_DAY : S_IDLE;
      S_DAY:       state_next = stat.div_last ? S_HOUR_INIT : S_DAY;
      S_HOUR_INIT: state_next = S_HOUR;
      S_HOUR:      state_next = stat.div_last ? S_MIN_INIT : S_HOUR;
      S_MIN_INIT:  state_next = S_MIN;
      S_MIN:       state_next = stat.div_last ? S_WDAY_INIT : S_MIN;
      S_WDAY_INIT: state_next = S_WDAY;
      S_WDAY:      state_next = stat.div_last ? S_YEAR : S_WDAY;
      S_YEAR:      state_next = stat.year_done ? S_MONTH : S_YEAR;
      S_MONTH:     state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    case (state)
      S_IDLE:      op = start ? OP_LOAD : OP_NONE;
      S_DAY:       op = OP_DIV;
      S_HOUR_INIT: op = OP_HOUR_INIT;
      S_HOUR:      op = OP_DIV;
      S_MIN_INIT:  op = OP_MIN_INIT;
      S_MIN:       op = OP_DIV;
      S_WDAY_INIT: op = OP_WDAY_INIT;
      S_WDAY:      op = OP_DIV;
      S_YEAR:      op = OP_YEAR;
      S_MONTH:     op = OP_MONTH;
      S_DONE:      op = OP_DONE;
      default:     op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/core/twpm_dp.sv
module twpm_dp
  import twpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  cfg_t        cfg,
  input  logic [31:0] timestamp_seconds,
  output dp_stat_t    stat,
  output logic        done,
  output logic        matched,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [2:0]  weekday,
  output logic [11:0] year_number,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month
);

  localparam int SUM_W = REM_W + 2;

  logic [REM_W-1:0] rem;
  logic [QUO_W-1:0] quo, days;
  logic [CNT_W-1:0] cnt;
  div_sel_t         dsel;
  logic [4:0]       hour;
  logic [5:0]       minute, sec;
  logic [2:0]       wday;
  logic [11:0]      year;
  logic [1:0]       y4;
  logic [6:0]       y100;
  logic [8:0]       y400;
  logic [3:0]       mon;
  logic [4:0]       mday;

  logic signed [SUM_W-1:0] t_sum;
  logic [REM_W-1:0]        ut;
  logic [52:0]             day_prod;
  logic [26:0]             hour_prod;
  logic [20:0]             min_prod;
  logic [32:0]             wday_prod;
  logic [QUO_W-1:0]        quo_calc;
  logic [16:0]             dval;
  logic [REM_W-1:0]        sub_prod;
  logic                    leap;
  logic [8:0]              year_len;
  logic [3:0]              mon_sel;
  logic [8:0]              mstart_sel;
  logic [4:0]              mday_calc;
  logic [10:0]             min_of_day;
  logic                    day_ok, time_ok;

  always_comb begin
    t_sum = $signed(SUM_W'(timestamp_seconds))
          + SUM_W'(cfg.extra_offset_seconds)
          - (SUM_W'(cfg.tz_minutes_west) <<< 6)
          + (SUM_W'(cfg.tz_minutes_west) <<< 2);
    ut = t_sum[SUM_W-1] ? '0 : t_sum[REM_W-1:0];
  end

  // first step: quotient by reciprocal; second step: remainder by multiply-subtract
  always_comb begin
    day_prod  = 53'(rem[REM_W-1:7]) * 53'(DAY_RECIP);
    hour_prod = 27'(rem[16:4]) * 27'(HOUR_RECIP);
    min_prod  = 21'(rem[11:2]) * 21'(MIN_RECIP);
    wday_prod = 33'(rem[15:0]) * 33'(WDAY_RECIP);
    case (dsel)
      DIV_DAY: begin
        quo_calc = QUO_W'(day_prod >> DAY_RSHIFT);
        dval     = 17'(SECS_PER_DAY);
      end
      DIV_HOUR: begin
        quo_calc = QUO_W'(hour_prod >> HOUR_RSHIFT);
        dval     = 17'(SECS_PER_HOUR);
      end
      DIV_MIN: begin
        quo_calc = QUO_W'(min_prod >> MIN_RSHIFT);
        dval     = 17'(SECS_PER_MIN);
      end
      DIV_WDAY: begin
        quo_calc = QUO_W'(wday_prod >> WDAY_RSHIFT);
        dval     = 17'(DAYS_PER_WEEK);
      end
      default: begin
        quo_calc = '0;
        dval     = '0;
      end
    endcase
    sub_prod = REM_W'(quo) * REM_W'(dval);
  end

  assign leap     = (y4 == 2'd0) && ((y100 != 7'd0) || (y400 == 9'd0));
  assign year_len = leap ? DAYS_LEAP : DAYS_COMMON;

  assign stat.div_last  = (cnt == '0);
  assign stat.year_done = (days < QUO_W'(year_len));

  always_comb begin
    logic [8:0] s;
    mon_sel    = 4'd0;
    mstart_sel = 9'd0;
    for (int m = 1; m < 12; m++) begin
      s = month_start(4'(m)) + ((m >= 2) ? {8'd0, leap} : 9'd0);
      if (s <= days[8:0]) begin
        mon_sel    = 4'(m);
        mstart_sel = s;
      end
    end
    mday_calc = 5'(days[8:0] - mstart_sel + 9'd1);
  end

  always_comb begin
    min_of_day = (11'(hour) << 6) - (11'(hour) << 2) + 11'(minute);
    day_ok     = (cfg.day_mask == 7'd0) || cfg.day_mask[3'd6 - wday];
    time_ok    = (min_of_day >= cfg.start_minute) && (min_of_day <= cfg.stop_minute);
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        rem  <= ut;
        dsel <= DIV_DAY;
        cnt  <= CNT_W'(DIV_STEPS - 1);
        quo  <= '0;
        year <= EPOCH_YEAR;
        y4   <= EPOCH_MOD4;
        y100 <= EPOCH_MOD100;
        y400 <= EPOCH_MOD400;
      end
      OP_DIV: begin
        if (cnt != '0) begin
          quo <= quo_calc;
        end else begin
          rem <= rem - sub_prod;
        end
        cnt <= cnt - 1'b1;
      end
      OP_HOUR_INIT: begin
        days <= quo;
        dsel <= DIV_HOUR;
        cnt  <= CNT_W'(DIV_STEPS - 1);
      end
      OP_MIN_INIT: begin
        hour <= quo[4:0];
        dsel <= DIV_MIN;
        cnt  <= CNT_W'(DIV_STEPS - 1);
      end
      OP_WDAY_INIT: begin
        minute <= quo[5:0];
        sec    <= rem[5:0];
        rem    <= REM_W'(days) + REM_W'(EPOCH_WDAY);
        dsel   <= DIV_WDAY;
        cnt    <= CNT_W'(DIV_STEPS - 1);
      end
      OP_YEAR: begin
        wday <= rem[2:0];
        if (!stat.year_done) begin
          days <= days - QUO_W'(year_len);
          year <= year + 12'd1;
          y4   <= y4 + 2'd1;
          y100 <= (y100 == 7'd99) ? 7'd0 : y100 + 7'd1;
          y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
        end
      end
      OP_MONTH: begin
        mon  <= mon_sel;
        mday <= mday_calc;
      end
      OP_DONE: begin
        matched          <= day_ok && time_ok;
        second_of_minute <= sec;
        minute_of_hour   <= minute;
        hour_of_day      <= hour;
        weekday          <= wday;
        year_number      <= year;
        month_index      <= mon;
        day_of_month     <= mday;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (op == OP_DONE);
    end
  end

endmodule

FILE: rtl/core/time_window_packet_match.sv
// The year subtraction loop (one year per cycle) dominates the time to done.
// The block takes one timestamp at a time; the next start is taken in the done cycle.
// Constant dividers: reciprocal multiply, then multiply-subtract, for each split.
// done is high for a single cycle; the result fields hold until the next result.
// The receiver cannot stall.
// Reset (rst, synchronous): controller idle, registers to defaults, no strobe.
module time_window_packet_match
  import twpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       timestamp_seconds,
  output logic              done,
  output logic              matched,
  output logic [5:0]        second_of_minute,
  output logic [5:0]        minute_of_hour,
  output logic [4:0]        hour_of_day,
  output logic [2:0]        weekday,
  output logic [11:0]       year_number,
  output logic [3:0]        month_index,
  output logic [4:0]        day_of_month,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg;
  op_t      op;
  dp_stat_t stat;

  twpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  twpm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .op    (op)
  );

  twpm_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .op                (op),
    .cfg               (cfg),
    .timestamp_seconds (timestamp_seconds),
    .stat              (stat),
    .done              (done),
    .matched           (matched),
    .second_of_minute  (second_of_minute),
    .minute_of_hour    (minute_of_hour),
    .hour_of_day       (hour_of_day),
    .weekday           (weekday),
    .year_number       (year_number),
    .month_index       (month_index),
    .day_of_month      (day_of_month)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !done || $past(busy))
    else $error("result strobe without work in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (weekday <= 3'd6 && month_index <= 4'd11 && day_of_month != 5'd0
              && hour_of_day <= 5'd23 && minute_of_hour <= 6'd59
              && second_of_minute <= 6'd59))
    else $error("result field out of range");

  a_match_window: assert property (@(posedge clk) disable iff (rst)
    (done && matched) |->
      (((11'(hour_of_day) << 6) - (11'(hour_of_day) << 2) + 11'(minute_of_hour))
        >= cfg.start_minute))
    else $error("match outside minute window");
`endif

endmodule

FILE: tb/time_window_packet_match_test.sv
module time_window_packet_match_test;
  import twpm_pkg::*;

  localparam int UNMAPPED_REG = 5;
  localparam int HOLD_MAX = 16;
  localparam int PHASES = 14;
  localparam int STAMPS_PER_PHASE = 120;
  localparam int DAY_SECS = 86400;

  typedef struct {
    logic        matched;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [2:0]  weekday;
    logic [11:0] year_number;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
  } local_time_t;

  localparam int MONTH_FIRST_DAY [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [31:0] timestamp_seconds = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy;
  logic done;
  logic matched;
  logic [5:0] second_of_minute;
  logic [5:0] minute_of_hour;
  logic [4:0] hour_of_day;
  logic [2:0] weekday;
  logic [11:0] year_number;
  logic [3:0] month_index;
  logic [4:0] day_of_month;
  logic [31:0] prdata;
  logic pready;

  cfg_t model_cfg;
  bit [31:0] stamp_queue[$];
  local_time_t expected_local_times[$];
  int hold = 0;
  bit idle_on = 1'b1;
  int errors = 0;
  int stamps_sent = 0;
  int results_checked = 0;
  int settings_done = 0;

  time_window_packet_match dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .timestamp_seconds(timestamp_seconds),
    .done(done),
    .matched(matched),
    .second_of_minute(second_of_minute),
    .minute_of_hour(minute_of_hour),
    .hour_of_day(hour_of_day),
    .weekday(weekday),
    .year_number(year_number),
    .month_index(month_index),
    .day_of_month(day_of_month),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #12000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic local_time_t predict_local_time(bit [31:0] ts);
    longint t;
    int unsigned sod, days, yr, rest, len, mon, first, minute_of_day;
    bit leap_add, day_ok;
    local_time_t r;
    t = longint'(ts) + longint'($signed(model_cfg.extra_offset_seconds))
        - longint'($signed(model_cfg.tz_minutes_west)) * 60;
    if (t < 0) t = 0;
    sod = 32'(t % DAY_SECS);
    days = 32'(t / DAY_SECS);
    yr = 1970;
    rest = days;
    forever begin
      len = leap_year(yr) ? 366 : 365;
      if (rest < len) break;
      rest -= len;
      yr++;
    end
    leap_add = leap_year(yr);
    mon = 11;
    first = 0;
    while (mon > 0) begin
      first = MONTH_FIRST_DAY[mon] + ((mon >= 2) ? 32'(leap_add) : 0);
      if (first <= rest) break;
      mon--;
    end
    if (mon == 0) first = 0;
    r.second_of_minute = 6'(sod % 60);
    r.minute_of_hour = 6'((sod / 60) % 60);
    r.hour_of_day = 5'(sod / 3600);
    r.weekday = 3'((3 + days) % 7);
    r.year_number = 12'(yr);
    r.month_index = 4'(mon);
    r.day_of_month = 5'(rest - first + 1);
    minute_of_day = (sod / 3600) * 60 + (sod / 60) % 60;
    day_ok = (model_cfg.day_mask == 0) || model_cfg.day_mask[6 - r.weekday];
    r.matched = day_ok && (minute_of_day >= model_cfg.start_minute)
                && (minute_of_day <= model_cfg.stop_minute);
    return r;
  endfunction

  function automatic bit [31:0] pick_stamp();
    longint s;
    int unsigned yr, mon, days;
    case ($urandom_range(0, 5))
      3: s = longint'($urandom_range(0, 49710)) * DAY_SECS
             + longint'($urandom_range(0, 2)) - 1;
      4: begin
        yr = $urandom_range(1970, 2105);
        mon = $urandom_range(0, 11);
        days = 0;
        for (int y = 1970; y < yr; y++) days += leap_year(y) ? 366 : 365;
        days += MONTH_FIRST_DAY[mon] + ((mon >= 2 && leap_year(yr)) ? 1 : 0);
        s = longint'(days) * DAY_SECS + longint'($urandom_range(0, 4)) - 2;
      end
      5: s = longint'($urandom_range(0, 300000));
      default: s = longint'($urandom);
    endcase
    return s[31:0];
  endfunction

  task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic write_reg(int idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DAY_MASK:  model_cfg.day_mask = data[6:0];
      REG_START_MIN: model_cfg.start_minute = data[10:0];
      REG_STOP_MIN:  model_cfg.stop_minute = data[10:0];
      REG_TZ_WEST:   model_cfg.tz_minutes_west = data[10:0];
      REG_EXTRA_OFS: model_cfg.extra_offset_seconds = data[17:0];
      default: ;
    endcase
  endtask

  // upper bits of each write carry junk the block must drop
  task automatic set_config(logic [6:0] dm, logic [10:0] st, logic [10:0] sp,
                            int tz, int ex);
    logic [31:0] w;
    w = $urandom; w[6:0] = dm;         write_reg(REG_DAY_MASK, w);
    w = $urandom; w[10:0] = st;        write_reg(REG_START_MIN, w);
    w = $urandom; w[10:0] = sp;        write_reg(REG_STOP_MIN, w);
    w = $urandom; w[10:0] = tz[10:0];  write_reg(REG_TZ_WEST, w);
    w = $urandom; w[17:0] = ex[17:0];  write_reg(REG_EXTRA_OFS, w);
    settings_done++;
  endtask

  task automatic random_config();
    logic [6:0] dm;
    logic [10:0] st, sp;
    int tz, ex;
    case ($urandom_range(0, 3))
      0: dm = 7'd0;
      1: dm = 7'h7f;
      default: dm = 7'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: begin st = 11'd0; sp = 11'd1439; end
      1: begin st = 11'($urandom); sp = 11'($urandom); end
      2: begin
        st = 11'($urandom_range(0, 1439));
        sp = 11'($urandom_range(32'(st), 1439));
      end
      default: begin
        st = 11'($urandom_range(0, 1439));
        sp = 11'($urandom_range(0, 1439));
      end
    endcase
    case ($urandom_range(0, 4))
      0: tz = -720;
      1: tz = 840;
      2: tz = int'($signed(11'($urandom)));
      default: tz = int'($urandom_range(0, 1560)) - 720;
    endcase
    case ($urandom_range(0, 4))
      0: ex = -86400;
      1: ex = 86400;
      2: ex = int'($signed(18'($urandom)));
      default: ex = int'($urandom_range(0, 172800)) - 86400;
    endcase
    set_config(dm, st, sp, tz, ex);
  endtask

  task automatic drain();
    @(negedge clk);
    while (stamp_queue.size() != 0 || start || expected_local_times.size() != 0)
      @(negedge clk);
  endtask

  // driver: holds start until the transfer, then waits its drawn idle count
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      hold <= 0;
    end else begin
      if (start && !busy) begin
        expected_local_times.push_back(predict_local_time(timestamp_seconds));
        stamps_sent++;
      end
      if (!start || !busy) begin
        if (hold != 0) begin
          start <= 1'b0;
          timestamp_seconds <= $urandom;
          if (!busy) hold <= hold - 1;
        end else if (stamp_queue.size() != 0) begin
          timestamp_seconds <= stamp_queue.pop_front();
          start <= 1'b1;
          hold <= idle_on ? int'($urandom_range(0, HOLD_MAX)) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    local_time_t want;
    if (!rst && done) begin
      if (expected_local_times.size() == 0) begin
        errors++;
        $display("%0t: result with no transfer pending, actual year %0d", $time, year_number);
      end else begin
        want = expected_local_times.pop_front();
        check_field("matched", 12'(want.matched), 12'(matched));
        check_field("second_of_minute", 12'(want.second_of_minute), 12'(second_of_minute));
        check_field("minute_of_hour", 12'(want.minute_of_hour), 12'(minute_of_hour));
        check_field("hour_of_day", 12'(want.hour_of_day), 12'(hour_of_day));
        check_field("weekday", 12'(want.weekday), 12'(weekday));
        check_field("year_number", want.year_number, year_number);
        check_field("month_index", 12'(want.month_index), 12'(month_index));
        check_field("day_of_month", 12'(want.day_of_month), 12'(day_of_month));
        results_checked++;
      end
    end
  end

  initial begin
    model_cfg.day_mask = DEF_DAY_MASK;
    model_cfg.start_minute = DEF_START;
    model_cfg.stop_minute = DEF_STOP;
    model_cfg.tz_minutes_west = '0;
    model_cfg.extra_offset_seconds = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // defaults: field edges, leap days, century non-leap, top of range
    stamp_queue = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
                    32'd68169600, 32'd94694399, 32'd951782400, 32'd951868800,
                    32'd2147483647, 32'd4107542399, 32'd4107542400, 32'hffffffff};
    drain();

    // negative local time saturates
    set_config(7'd0, 11'd0, 11'd1439, 840, -86400);
    stamp_queue = '{32'd0, 32'd136799, 32'd136800};
    drain();

    // largest sums stay in 2106, then the most negative offsets
    set_config(7'h7f, 11'd0, 11'd2047, -1024, 131071);
    stamp_queue.push_back(32'hffffffff);
    drain();
    set_config(7'h7f, 11'd0, 11'd1439, -720, 86400);
    stamp_queue.push_back(32'hffffffff);
    drain();
    set_config(7'd0, 11'd0, 11'd1439, 1023, -131072);
    stamp_queue.push_back(32'h00030000);
    drain();

    // weekday mask and window edges
    set_config(7'b1000000, 11'd600, 11'd600, 0, 0);
    stamp_queue = '{32'd381600, 32'd381660, 32'd468000};
    drain();
    write_reg(UNMAPPED_REG, $urandom);
    set_config(7'b0000001, 11'd2047, 11'd2047, 0, 0);
    stamp_queue.push_back(32'd295200);
    drain();
    set_config(7'd0, 11'd900, 11'd100, 0, 0);
    stamp_queue.push_back(32'd54000);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p % 3 != 0);
      random_config();
      for (int n = 0; n < STAMPS_PER_PHASE; n++) stamp_queue.push_back(pick_stamp());
      drain();
    end

    repeat (200) @(posedge clk);
    if (expected_local_times.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected year %0d", $time,
               expected_local_times.size(), expected_local_times[0].year_number);
    end
    $display("Checked %0d of %0d timestamps under %0d register settings, %0d errors",
             results_checked, stamps_sent, settings_done, errors);
    $display("Covered saturation, leap rules, weekday masks and out-of-range windows");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/twpm_pkg.sv
rtl/core/twpm_regs.sv
rtl/core/twpm_ctrl.sv
rtl/core/twpm_dp.sv
rtl/core/time_window_packet_match.sv
tb/time_window_packet_match_test.sv
